/* sv/qdd_pkg.sv */
// shared types, constants and table functions for the quadrature detent decoder
package qdd_pkg;

  localparam int unsigned PINS_W     = 2;
  localparam int unsigned GRAN_W     = 4;
  localparam int unsigned ACCUM_W    = 8;
  localparam int unsigned POSITION_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRANULARITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INVERT      = 1'b1;

  localparam logic [GRAN_W-1:0] GRAN_RESET = 4'd4;

  localparam logic [PINS_W-1:0] PINS_LOW  = 2'd0;
  localparam logic [PINS_W-1:0] PINS_HIGH = 2'd3;

  typedef logic [PINS_W-1:0]         pins_t;
  typedef logic signed [1:0]         moved_t;
  typedef logic signed [2:0]         step_t;
  typedef logic signed [ACCUM_W-1:0] accum_t;

  localparam moved_t MOVED_NONE = 2'sd0;
  localparam moved_t MOVED_UP   = 2'sd1;
  localparam moved_t MOVED_DOWN = -2'sd1;

  function automatic logic at_detent(input pins_t p);
    return (p == PINS_LOW) || (p == PINS_HIGH);
  endfunction

  // signed step for a move from pins a to pins b
  function automatic step_t step_lookup(input pins_t a, input pins_t b);
    step_t s;
    case ({a, b})
      4'b00_00: s = 3'sd0;
      4'b00_01: s = 3'sd1;
      4'b00_10: s = -3'sd1;
      4'b00_11: s = 3'sd2;
      4'b01_00: s = -3'sd1;
      4'b01_01: s = 3'sd0;
      4'b01_10: s = 3'sd0;
      4'b01_11: s = 3'sd1;
      4'b10_00: s = 3'sd1;
      4'b10_01: s = 3'sd0;
      4'b10_10: s = 3'sd0;
      4'b10_11: s = -3'sd1;
      4'b11_00: s = -3'sd2;
      4'b11_01: s = -3'sd1;
      4'b11_10: s = 3'sd1;
      4'b11_11: s = 3'sd0;
      default:  s = 3'sd0;
    endcase
    return s;
  endfunction

endpackage

/* sv/qdd_if.sv */
// valid/ready channel interfaces for pin samples and position results
interface qdd_in_if;
  logic          valid;
  logic          ready;
  qdd_pkg::pins_t pin_state;
  logic          enter_held;

  modport source (output valid, output pin_state, output enter_held, input ready);
  modport sink   (input valid, input pin_state, input enter_held, output ready);
endinterface

interface qdd_out_if;
  logic            valid;
  logic            ready;
  logic [31:0]     position;
  qdd_pkg::moved_t moved;

  modport source (output valid, output position, output moved, input ready);
  modport sink   (input valid, input position, input moved, output ready);
endinterface

/* sv/quadrature_detent_decoder.sv */
// quadrature detent decoder top level: sample register, state update, result register
// Takes one pin sample per clock while results are taken, and returns one result
// per sample, in order. A sample lands in an input register; its state update
// (table lookup, accumulator add with saturation, detent compare, position step)
// runs in one pass and fills the result register once that register is empty or
// its result is being taken, so the sustained rate is one item per cycle while the
// receiver keeps taking results. While a result waits to be taken the input register
// can still take one sample. Granularity and direction are written through the config
// port; the user must keep such writes to idle, as the block does not enforce it.
module quadrature_detent_decoder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qdd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qdd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  qdd_in_if.sink                     in_if,
  qdd_out_if.source                  out_if
);
  import qdd_pkg::*;

  logic [GRAN_W-1:0] gran_q;
  logic              invert_q;

  logic  in_valid_q;
  pins_t in_pins_q;
  logic  in_enter_q;

  pins_t                  last_pins_q, last_pins_d;
  accum_t                 accum_q, accum_d;
  logic                   skip_q, skip_d;
  logic                   primed_q, primed_d;
  logic [COUNT_WIDTH-1:0] pos_q, pos_d;
  moved_t                 moved_d;

  logic                  out_valid_q;
  logic [POSITION_W-1:0] out_pos_q, out_pos_d;
  moved_t                out_moved_q;

  logic advance;

  logic [GRAN_W-1:0]        gran_eff;
  step_t                    step_raw, step_dir;
  logic signed [ACCUM_W+1:0] sum, sum_sat, gran_s;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  assign out_if.valid    = out_valid_q;
  assign out_if.position = out_pos_q;
  assign out_if.moved    = out_moved_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q   <= GRAN_RESET;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_GRANULARITY: gran_q   <= cfg_data_i[GRAN_W-1:0];
        CFG_IDX_INVERT:      invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_pins_q  <= in_if.pin_state;
      in_enter_q <= in_if.enter_held;
    end
  end

  // accumulator arithmetic
  always_comb begin
    gran_eff = (gran_q == '0) ? GRAN_W'(1) : gran_q;
    gran_s   = $signed({{(ACCUM_W+2-GRAN_W){1'b0}}, gran_eff});
    step_raw = step_lookup(last_pins_q, in_pins_q);
    step_dir = invert_q ? -step_raw : step_raw;
    sum      = $signed({{2{accum_q[ACCUM_W-1]}}, accum_q})
             + $signed({{(ACCUM_W-1){step_dir[2]}}, step_dir});
    if (sum > $signed((ACCUM_W+2)'(127))) begin
      sum_sat = (ACCUM_W+2)'(127);
    end else if (sum < -$signed((ACCUM_W+2)'(128))) begin
      sum_sat = -$signed((ACCUM_W+2)'(128));
    end else begin
      sum_sat = sum;
    end
  end

  // next state for the sample in the input register
  always_comb begin
    last_pins_d = last_pins_q;
    accum_d     = accum_q;
    skip_d      = skip_q;
    primed_d    = primed_q;
    moved_d     = MOVED_NONE;
    if (!primed_q) begin
      primed_d    = 1'b1;
      last_pins_d = in_pins_q;
      skip_d      = !at_detent(in_pins_q);
    end else if (in_pins_q == last_pins_q) begin
      // unchanged pins leave everything alone
    end else if (skip_q) begin
      if (at_detent(in_pins_q)) begin
        last_pins_d = in_pins_q;
        skip_d      = 1'b0;
      end
    end else begin
      last_pins_d = in_pins_q;
      if (sum_sat >= gran_s) begin
        accum_d = ACCUM_W'(sum_sat - gran_s);
        if (!in_enter_q) begin
          moved_d = MOVED_UP;
        end
      end else if (sum_sat <= -gran_s) begin
        accum_d = ACCUM_W'(sum_sat + gran_s);
        if (!in_enter_q) begin
          moved_d = MOVED_DOWN;
        end
      end else begin
        accum_d = ACCUM_W'(sum_sat);
      end
    end
  end

  always_comb begin
    case (moved_d)
      MOVED_UP:   pos_d = pos_q + COUNT_WIDTH'(1);
      MOVED_DOWN: pos_d = pos_q - COUNT_WIDTH'(1);
      default:    pos_d = pos_q;
    endcase
  end

  generate
    if (COUNT_WIDTH >= POSITION_W) begin : g_pos_trunc
      assign out_pos_d = pos_d[POSITION_W-1:0];
    end else begin : g_pos_ext
      assign out_pos_d = {{(POSITION_W-COUNT_WIDTH){1'b0}}, pos_d};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
      accum_q     <= '0;
      skip_q      <= 1'b0;
      primed_q    <= 1'b0;
      pos_q       <= '0;
    end else if (advance) begin
      last_pins_q <= last_pins_d;
      accum_q     <= accum_d;
      skip_q      <= skip_d;
      primed_q    <= primed_d;
      pos_q       <= pos_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pos_q   <= out_pos_d;
      out_moved_q <= moved_d;
    end
  end

`ifndef SYNTHESIS
  a_skip_needs_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> primed_q)
    else $error("skip mode set before the first sample");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with no item waiting");

  a_move_changes_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && moved_d != MOVED_NONE) |=> (pos_q != $past(pos_q)))
    else $error("reported move without a position change");

  a_still_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && moved_d == MOVED_NONE) |=> $stable(pos_q))
    else $error("position changed without a reported move");
`endif

endmodule

/* sim/qdd_result_checker.sv */
// result checker: tracks decoder state from accepted samples and compares every result
module qdd_result_checker
  import qdd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  qdd_in_if                     in_mon,
  qdd_out_if                    out_mon,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    moved_t                moved;
  } position_result_t;

  localparam int MAX_REPORTS = 10;
  localparam int ACCUM_MAX   = 127;
  localparam int ACCUM_MIN   = -128;

  // increment for a move from row pins to column pins
  localparam int STEP_TABLE [0:3][0:3] = '{
    '{ 0,  1, -1,  2},
    '{-1,  0,  0,  1},
    '{ 1,  0,  0, -1},
    '{-2, -1,  1,  0}
  };

  logic [GRAN_W-1:0]     trk_gran;
  logic                  trk_invert;
  pins_t                 trk_last;
  accum_t                trk_accum;
  logic                  trk_skip;
  logic                  trk_primed;
  logic [POSITION_W-1:0] trk_position;

  position_result_t expected_positions[$];
  int unsigned      mismatches;

  function automatic position_result_t decode_sample(input pins_t pins, input logic enter);
    position_result_t res;
    int gran;
    int inc;
    int sum;
    res.moved = MOVED_NONE;
    if (!trk_primed) begin
      trk_primed = 1'b1;
      trk_last   = pins;
      trk_skip   = !(pins == PINS_LOW || pins == PINS_HIGH);
    end else if (pins != trk_last) begin
      if (trk_skip) begin
        // waiting for the pins to settle on a detent
        if (pins == PINS_LOW || pins == PINS_HIGH) begin
          trk_last = pins;
          trk_skip = 1'b0;
        end
      end else begin
        gran = (trk_gran == '0) ? 1 : int'(trk_gran);
        inc  = STEP_TABLE[trk_last][pins];
        if (trk_invert) begin
          inc = -inc;
        end
        sum = int'(trk_accum) + inc;
        if (sum > ACCUM_MAX) begin
          sum = ACCUM_MAX;
        end
        if (sum < ACCUM_MIN) begin
          sum = ACCUM_MIN;
        end
        // enter held still pulls the accumulator back, only the move is dropped
        if (sum >= gran) begin
          if (!enter) begin
            res.moved = MOVED_UP;
          end
          sum -= gran;
        end else if (sum <= -gran) begin
          if (!enter) begin
            res.moved = MOVED_DOWN;
          end
          sum += gran;
        end
        trk_accum = accum_t'(sum);
        if (res.moved == MOVED_UP) begin
          trk_position = trk_position + 1'b1;
        end else if (res.moved == MOVED_DOWN) begin
          trk_position = trk_position - 1'b1;
        end
        trk_last = pins;
      end
    end
    res.position = trk_position;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_result_t exp_res;
    position_result_t got_res;
    if (!rst_ni) begin
      trk_gran     = GRAN_RESET;
      trk_invert   = 1'b0;
      trk_last     = '0;
      trk_accum    = '0;
      trk_skip     = 1'b0;
      trk_primed   = 1'b0;
      trk_position = '0;
      mismatches   = 0;
      expected_positions.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IDX_GRANULARITY) begin
          trk_gran = cfg_data_i[GRAN_W-1:0];
        end else if (cfg_index_i == CFG_IDX_INVERT) begin
          trk_invert = cfg_data_i[0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got_res.position = out_mon.position;
        got_res.moved    = out_mon.moved;
        if (expected_positions.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("checker: unexpected result position %h moved %0d",
                     got_res.position, got_res.moved);
          end
          mismatches++;
        end else begin
          exp_res = expected_positions.pop_front();
          if (got_res.position !== exp_res.position || got_res.moved !== exp_res.moved) begin
            if (mismatches < MAX_REPORTS) begin
              $display("checker: mismatch position exp %h got %h, moved exp %0d got %0d",
                       exp_res.position, got_res.position, exp_res.moved, got_res.moved);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_positions.push_back(decode_sample(in_mon.pin_state, in_mon.enter_held));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_positions.size();
    end
  end

endmodule

/* sim/quadrature_detent_decoder_tb.sv */
// testbench top: clock, reset, config writes and pin sample stimulus for the detent decoder
module quadrature_detent_decoder_tb;
  import qdd_pkg::*;

  localparam int CHUNK_ITEMS = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned chunk_count;
  pins_t       cur_pins;
  logic        fwd_dir;

  // idle mix per chunk: none, sender, receiver, both
  int unsigned sender_idle_mix   [0:3] = '{0, 76, 0, 33};
  int unsigned receiver_stall_mix[0:3] = '{0, 0, 76, 33};

  qdd_in_if  sample_ch ();
  qdd_out_if result_ch ();

  quadrature_detent_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (sample_ch),
    .out_if      (result_ch)
  );

  qdd_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_mon       (sample_ch),
    .out_mon      (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic pins_t gray_step(input pins_t p, input logic fwd);
    pins_t n;
    case (p)
      2'd0:    n = fwd ? 2'd1 : 2'd2;
      2'd1:    n = fwd ? 2'd3 : 2'd0;
      2'd3:    n = fwd ? 2'd2 : 2'd1;
      default: n = fwd ? 2'd0 : 2'd3;
    endcase
    return n;
  endfunction

  task automatic set_idle_mode(input int unsigned mode);
    sender_idle_pct    = sender_idle_mix[mode];
    receiver_stall_pct = receiver_stall_mix[mode];
  endtask

  // called right after a rising edge; leaves valid high after the handshake
  task automatic send_sample(input pins_t pins, input logic enter);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.pin_state  <= pins;
    sample_ch.enter_held <= enter;
    @(posedge clk_i);
    while (!sample_ch.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // one write, then cfg_we is dropped before returning so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // spin walks forward, jumps 0 to 3: accum creeps up (down if inverted) until it saturates
  task automatic run_phase(input int unsigned gran, input logic invert, input int unsigned count,
                           input logic spin);
    int unsigned r;
    pins_t       nxt;
    logic        enter;
    drain_results();
    write_reg(CFG_IDX_GRANULARITY, CFG_DATA_W'(gran));
    write_reg(CFG_IDX_INVERT, CFG_DATA_W'(invert));
    for (int unsigned i = 0; i < count; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        set_idle_mode(chunk_count % 4);
        chunk_count++;
      end
      r = $urandom_range(99);
      if (spin) begin
        if (r < 5) begin
          nxt = pins_t'($urandom_range(3));
        end else if (cur_pins == PINS_LOW) begin
          nxt = PINS_HIGH;
        end else begin
          nxt = gray_step(cur_pins, 1'b1);
        end
      end else begin
        if ($urandom_range(19) == 0) begin
          fwd_dir = ~fwd_dir;
        end
        if (r < 60) begin
          nxt = gray_step(cur_pins, fwd_dir);
        end else if (r < 70) begin
          nxt = cur_pins;
        end else if (r < 80) begin
          nxt = cur_pins ^ 2'b11;
        end else begin
          nxt = pins_t'($urandom_range(3));
        end
      end
      enter = ($urandom_range(99) < 20);
      send_sample(nxt, enter);
      cur_pins = nxt;
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    static pins_t directed_pins [25] = '{2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2,
                                         2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3,
                                         2'd1, 2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 2'd0};
    static logic  directed_enter[25] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.pin_state  <= '0;
    sample_ch.enter_held <= 1'b0;
    chunk_count          = 0;
    fwd_dir              = 1'b1;
    set_idle_mode(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // off-detent prime, skip until a detent, full detents both ways, enter held,
    // wrap below zero, double steps
    for (int i = 0; i < 25; i++) begin
      send_sample(directed_pins[i], directed_enter[i]);
    end
    cur_pins = directed_pins[24];

    run_phase(4, 1'b0, 100, 1'b0);
    run_phase(1, 1'b0, 500, 1'b1);
    run_phase(1, 1'b1, 520, 1'b1);
    run_phase(8, 1'b0, 60, 1'b0);
    run_phase(15, 1'b1, 60, 1'b0);
    run_phase(0, 1'b0, 60, 1'b0);
    drain_results();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/qdd_pkg.sv
sv/qdd_if.sv
sv/quadrature_detent_decoder.sv
sim/qdd_result_checker.sv
sim/quadrature_detent_decoder_tb.sv
